// File: hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int LEAF_BLOCKS_DEF    = 64;
    localparam int MIN_BLOCK_LOG2_DEF = 12;

    localparam int ADDR_W  = 32;
    localparam int WIDE_W  = 33;
    localparam int SHAMT_W = 6;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_TOO_BIG,
        STATUS_NO_FIT,
        STATUS_NOT_ALLOC
    } bba_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_A_RD,
        ST_A_EV,
        ST_A_UP,
        ST_F_RD,
        ST_F_EV,
        ST_M_B,
        ST_M_P,
        ST_M_EV
    } bba_state_t;

    typedef enum logic [2:0] {
        NODE_HOLD,
        NODE_ZERO,
        NODE_LEAF,
        NODE_INC,
        NODE_CHILD,
        NODE_PARENT
    } bba_node_op_t;

    typedef enum logic [1:0] {
        RD_NODE,
        RD_BUDDY,
        RD_PARENT
    } bba_rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_USED,
        WR_SPLIT,
        WR_MERGE
    } bba_wr_op_t;

    typedef struct packed {
        logic used;
        logic split;
    } bba_bits_t;

    typedef struct packed {
        logic         load;
        bba_node_op_t node_op;
        bba_rd_sel_t  rd_sel;
        bba_wr_op_t   wr_op;
        logic         kd_zero;
        logic         kd_step;
        logic         bd_load;
        logic         respond;
        bba_status_t  resp_status;
        logic         resp_addr;
    } bba_cmd_t;

    typedef struct packed {
        logic too_big;
        logic addr_bad;
        logic used;
        logic split;
        logic leaf;
        logic fit_here;
        logic node_zero;
        logic node_odd;
        logic parent_zero;
        logic sweep_last;
        logic merge_ok;
    } bba_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bba_ram.sv
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          operation,
    input  bba_pkg::bba_stat_t  stat,
    output bba_pkg::bba_cmd_t   cmd,
    output logic                busy
);

    import bba_pkg::*;

    bba_state_t state_reg;
    bba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.node_op     = NODE_HOLD;
        cmd.rd_sel      = RD_NODE;
        cmd.wr_op       = WR_NONE;
        cmd.resp_status = STATUS_DONE;
        busy            = (state_reg != ST_IDLE);

        case (state_reg)
            ST_INIT:
            begin
                cmd.wr_op   = WR_CLEAR;
                cmd.node_op = NODE_INC;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (operation)
                        OP_ALLOC:
                        begin
                            cmd.node_op = NODE_ZERO;
                            if (stat.too_big)
                            begin
                                cmd.respond     = 1'b1;
                                cmd.resp_status = STATUS_TOO_BIG;
                            end
                            else
                            begin
                                state_next = ST_A_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            cmd.node_op = NODE_LEAF;
                            if (stat.addr_bad)
                            begin
                                cmd.respond     = 1'b1;
                                cmd.resp_status = STATUS_NOT_ALLOC;
                            end
                            else
                            begin
                                state_next = ST_F_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.node_op = NODE_ZERO;
                            state_next  = ST_CLR;
                        end
                        default:
                        begin
                            cmd.respond = 1'b1;
                        end
                    endcase
                end
            end

            ST_CLR:
            begin
                cmd.wr_op   = WR_CLEAR;
                cmd.node_op = NODE_INC;
                if (stat.sweep_last)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_A_RD:
            begin
                cmd.rd_sel = RD_NODE;
                state_next = ST_A_EV;
            end

            ST_A_EV:
            begin
                if (stat.used)
                begin
                    state_next = ST_A_UP;
                end
                else if ((stat.fit_here || stat.leaf) && !stat.split)
                begin
                    cmd.wr_op     = WR_USED;
                    cmd.respond   = 1'b1;
                    cmd.resp_addr = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (stat.leaf || stat.fit_here)
                begin
                    state_next = ST_A_UP;
                end
                else
                begin
                    cmd.wr_op   = WR_SPLIT;
                    cmd.node_op = NODE_CHILD;
                    state_next  = ST_A_RD;
                end
            end

            ST_A_UP:
            begin
                if (stat.node_zero)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = STATUS_NO_FIT;
                    state_next      = ST_IDLE;
                end
                else if (stat.node_odd)
                begin
                    cmd.node_op = NODE_INC;
                    state_next  = ST_A_RD;
                end
                else
                begin
                    cmd.node_op = NODE_PARENT;
                end
            end

            ST_F_RD:
            begin
                cmd.rd_sel = RD_NODE;
                state_next = ST_F_EV;
            end

            ST_F_EV:
            begin
                if (stat.used)
                begin
                    cmd.wr_op   = WR_CLEAR;
                    cmd.kd_zero = 1'b1;
                    if (stat.node_zero)
                    begin
                        cmd.respond = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_M_B;
                    end
                end
                else if (stat.node_zero)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = STATUS_NOT_ALLOC;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.node_op = NODE_PARENT;
                    state_next  = ST_F_RD;
                end
            end

            ST_M_B:
            begin
                cmd.rd_sel = RD_BUDDY;
                state_next = ST_M_P;
            end

            ST_M_P:
            begin
                cmd.bd_load = 1'b1;
                cmd.rd_sel  = RD_PARENT;
                state_next  = ST_M_EV;
            end

            ST_M_EV:
            begin
                cmd.kd_step = 1'b1;
                cmd.node_op = NODE_PARENT;
                if (stat.merge_ok)
                begin
                    cmd.wr_op = WR_MERGE;
                end
                if (stat.parent_zero)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_M_B;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bba_dp.sv
`default_nettype none

module bba_dp #(
    parameter int LEAF_BLOCKS    = bba_pkg::LEAF_BLOCKS_DEF,
    parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         base_address_we,
    input  logic [bba_pkg::ADDR_W-1:0]   base_address,
    input  logic [bba_pkg::ADDR_W-1:0]   request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]   free_address,
    input  bba_pkg::bba_cmd_t            cmd,
    output bba_pkg::bba_stat_t           stat,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [bba_pkg::ADDR_W-1:0]   block_address
);

    import bba_pkg::*;

    localparam int LEAF_LOG   = $clog2(LEAF_BLOCKS);
    localparam int NODE_COUNT = 2 * LEAF_BLOCKS;
    localparam int NODE_W     = LEAF_LOG + 1;
    localparam int LVL_W      = $clog2(LEAF_LOG + 1);
    localparam int SPAN_LOG   = MIN_BLOCK_LOG2 + LEAF_LOG;

    localparam logic [NODE_W-1:0] FIRST_LEAF  = NODE_W'(LEAF_BLOCKS - 1);
    localparam logic [WIDE_W-1:0] TOTAL_BYTES = WIDE_W'(1) << SPAN_LOG;

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] want_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] node_next;
    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    bba_bits_t         kd_reg;
    bba_bits_t         kd_next;
    bba_bits_t         bd_reg;
    logic              done_reg;
    bba_status_t       status_reg;
    logic [ADDR_W-1:0] block_address_reg;

    logic [NODE_W-1:0]  node_inc;
    logic [NODE_W-1:0]  node_dec;
    logic [NODE_W-1:0]  node_child;
    logic [NODE_W-1:0]  node_parent;
    logic [NODE_W-1:0]  node_buddy;
    logic [NODE_W-1:0]  leaf_node;
    logic [ADDR_W-1:0]  disp;
    logic [ADDR_W-1:0]  blk_idx;
    logic [SHAMT_W-1:0] half_shamt;
    logic [WIDE_W-1:0]  half_bytes;
    logic [NODE_W-1:0]  pos;
    logic [WIDE_W-1:0]  offset;
    logic [ADDR_W-1:0]  take_addr;

    logic [NODE_W-1:0]  rd_addr;
    logic [NODE_W-1:0]  wr_addr;
    logic               wr_en;
    bba_bits_t          wr_bits;
    logic [1:0]         rd_word;
    bba_bits_t          rd_bits;

    assign node_inc    = node_reg + NODE_W'(1);
    assign node_dec    = node_reg - NODE_W'(1);
    assign node_child  = {node_reg[NODE_W-2:0], 1'b1};
    assign node_parent = node_dec >> 1;
    assign node_buddy  = node_reg[0] ? node_inc : node_dec;

    assign disp      = free_address - base_reg;
    assign blk_idx   = disp >> MIN_BLOCK_LOG2;
    assign leaf_node = FIRST_LEAF + NODE_W'(blk_idx[LEAF_LOG-1:0]);

    assign half_shamt = SHAMT_W'(SPAN_LOG - 1) - SHAMT_W'(level_reg);
    assign half_bytes = WIDE_W'(1) << half_shamt;

    // block offset = position within level times block size at that level
    assign pos       = node_inc - (NODE_W'(1) << level_reg);
    assign offset    = WIDE_W'(pos) << (SHAMT_W'(SPAN_LOG) - SHAMT_W'(level_reg));
    assign take_addr = base_reg + offset[ADDR_W-1:0];

    assign rd_bits = bba_bits_t'(rd_word);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NODE:   rd_addr = node_reg;
            RD_BUDDY:  rd_addr = node_buddy;
            RD_PARENT: rd_addr = node_parent;
            default:   rd_addr = node_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = node_reg;
        wr_bits = '0;
        case (cmd.wr_op)
            WR_CLEAR:
            begin
                wr_bits = '0;
            end
            WR_USED:
            begin
                wr_bits.used = 1'b1;
            end
            WR_SPLIT:
            begin
                wr_bits.split = 1'b1;
            end
            WR_MERGE:
            begin
                wr_addr      = node_parent;
                wr_bits.used = rd_bits.used;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    bba_ram #(
        .WIDTH ($bits(bba_bits_t)),
        .DEPTH (NODE_COUNT)
    ) u_bits_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_bits),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        node_next  = node_reg;
        level_next = level_reg;
        case (cmd.node_op)
            NODE_ZERO:
            begin
                node_next  = '0;
                level_next = '0;
            end
            NODE_LEAF:
            begin
                node_next  = leaf_node;
                level_next = LVL_W'(LEAF_LOG);
            end
            NODE_INC:
            begin
                node_next = node_inc;
            end
            NODE_CHILD:
            begin
                node_next  = node_child;
                level_next = level_reg + LVL_W'(1);
            end
            NODE_PARENT:
            begin
                node_next  = node_parent;
                level_next = level_reg - LVL_W'(1);
            end
            default:
            begin
                node_next = node_reg;
            end
        endcase
    end

    always_comb
    begin
        kd_next = kd_reg;
        if (cmd.kd_zero)
        begin
            kd_next = '0;
        end
        else if (cmd.kd_step)
        begin
            kd_next = rd_bits;
            if (stat.merge_ok)
            begin
                kd_next.split = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            node_reg  <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (base_address_we)
            begin
                base_reg <= base_address;
            end
            node_reg  <= node_next;
            level_reg <= level_next;
            done_reg  <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            want_reg <= request_bytes;
        end
        kd_reg <= kd_next;
        if (cmd.bd_load)
        begin
            bd_reg <= rd_bits;
        end
        if (cmd.respond)
        begin
            status_reg        <= cmd.resp_status;
            block_address_reg <= cmd.resp_addr ? take_addr : '0;
        end
    end

    always_comb
    begin
        stat.too_big     = {1'b0, request_bytes} > TOTAL_BYTES;
        stat.addr_bad    = blk_idx >= ADDR_W'(LEAF_BLOCKS);
        stat.used        = rd_bits.used;
        stat.split       = rd_bits.split;
        stat.leaf        = node_reg >= FIRST_LEAF;
        stat.fit_here    = {1'b0, want_reg} > half_bytes;
        stat.node_zero   = (node_reg == '0);
        stat.node_odd    = node_reg[0];
        stat.parent_zero = (node_parent == '0);
        stat.sweep_last  = &node_reg;
        stat.merge_ok    = (kd_reg == '0) && (bd_reg == '0);
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = block_address_reg;

endmodule

`default_nettype wire

// File: hw/rtl/buddy_block_allocator_top.sv
`default_nettype none

// Buddy allocator over LEAF_BLOCKS blocks of 2^MIN_BLOCK_LOG2 bytes from base_address.
// A request is taken when start is high and busy is low; its result comes back on
// done/status/block_address for exactly one cycle, in the cycle after the last step, and
// must be captured then since the block cannot be stalled. All node bits sit in one
// single-port-read RAM, so each node visit is a read state followed by a decide state.
// After the accept cycle, allocate visits nodes in turn, moving to a sibling or back up
// a level when one cannot hold the request; free checks the leaf and its ancestors until
// it finds the used one, then walks back to the root merging free buddies; clear sweeps
// every node; a rejected request or any other operation ends in the accept cycle.
// After reset busy stays high for a clearing pass over every node; write
// base_address only while no request is in flight.
module buddy_block_allocator_top #(
    parameter int LEAF_BLOCKS    = bba_pkg::LEAF_BLOCKS_DEF,
    parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        base_address_we,
    input  logic [bba_pkg::ADDR_W-1:0]  base_address,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [bba_pkg::ADDR_W-1:0]  request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  free_address,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [bba_pkg::ADDR_W-1:0]  block_address
);

    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    bba_dp #(
        .LEAF_BLOCKS    (LEAF_BLOCKS),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .base_address_we (base_address_we),
        .base_address    (base_address),
        .request_bytes   (request_bytes),
        .free_address    (free_address),
        .cmd             (cmd),
        .stat            (stat),
        .done            (done),
        .status          (status),
        .block_address   (block_address)
    );

    a_addr_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && (block_address != '0) |-> status == STATUS_DONE)
        else $error("block address returned with a failure status");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_CLEAR |=> busy && !done)
        else $error("clear request did not start a sweep");

endmodule

`default_nettype wire
